// File: rtl/core/spte_pkg.sv
package spte_pkg;

    localparam int SLOT_W   = 10;
    localparam int SLOTS    = 1 << SLOT_W;
    localparam int NODE_W   = 10;
    localparam int NODES    = 1 << NODE_W;
    localparam int WEIGHT_W = 32;
    localparam int ID_W     = 16;
    localparam int EPOCH_W  = 8;

    localparam int TREE_W = SLOT_W + 1 + WEIGHT_W + ID_W;
    localparam int MAP_W  = EPOCH_W + SLOT_W + 1;

    // Slot references carry one extra bit so that "no slot" is all ones.
    localparam logic [SLOT_W:0] NO_SLOT    = '1;
    localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W + 1)'(SLOTS);
    localparam logic [WEIGHT_W-1:0] INF_WEIGHT = '1;

    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_INSERT = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        STS_OK          = 3'd0,
        STS_RANGE       = 3'd1,
        STS_INFINITE    = 3'd2,
        STS_NOT_LAST    = 3'd3,
        STS_NOT_IN_TREE = 3'd4,
        STS_FULL        = 3'd5
    } status_t;

    typedef struct packed {
        logic [SLOT_W:0]     parent;
        logic [WEIGHT_W-1:0] weight;
        logic [ID_W-1:0]     edge_id;
    } tree_ent_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [SLOT_W:0]    slot;
    } map_ent_t;

    // Parent of a slot, or no slot when either side lies outside the live tree.
    function automatic logic [SLOT_W:0] up_of(input logic [SLOT_W:0] s,
                                              input logic [SLOT_W:0] par,
                                              input logic [SLOT_W:0] count);
        logic [SLOT_W:0] r;
        r = NO_SLOT;
        if (s < count && par < count)
        begin
            r = par;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/spte_ram.sv
module spte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/spanning_tree_edge_exchange_top.sv
// Start writes the root; add and remove look up the map; an infinite weight or a full tree
// answers without a lookup. An insertion looks up both ends, walks both depths, lifts the deeper
// end, climbs both ends together and, on an exchange, turns the path round (tree RAM reads are registered).
// One item is worked on at a time; a result waits in the output register while the next
// item is taken. A new item is taken only once the last has entered the output register.
// Reset clears every node map entry (not ready); the clear is repeated on every 256th start.
module spanning_tree_edge_exchange_top
    import spte_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // node_a, node_b, weight, edge_id, zero pad
    input  logic [1:0]   s_tuser,   // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // gain, removed_child, removed_parent,
                                    // removed_weight, removed_edge_id, path_start, path_end
    output logic [3:0]   m_tuser    // status, exchanged
);

    typedef enum logic [21:0] {
        S_IDLE   = 22'h000001,
        S_CLR    = 22'h000002,
        S_ST_FIN = 22'h000004,
        S_LK_A   = 22'h000008,
        S_LK_B   = 22'h000010,
        S_LK_CHK = 22'h000020,
        S_DEP_RD = 22'h000040,
        S_DEP_EV = 22'h000080,
        S_EQ_RD  = 22'h000100,
        S_EQ_EV  = 22'h000200,
        S_CL_RA  = 22'h000400,
        S_CL_RB  = 22'h000800,
        S_CL_EB  = 22'h001000,
        S_CL_CHK = 22'h002000,
        S_DECIDE = 22'h004000,
        S_RV_RE  = 22'h008000,
        S_RV_EE  = 22'h010000,
        S_RV_CHK = 22'h020000,
        S_RV_RD  = 22'h040000,
        S_RV_EV  = 22'h080000,
        S_RV_FIN = 22'h100000,
        S_OUT    = 22'h200000
    } state_t;

    state_t state_reg, state_next;

    logic [SLOT_W:0]   count_reg, count_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [SLOT_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              clr_start_reg, clr_start_next;
    logic              out_valid_reg, out_valid_next;
    logic [119:0]      out_data_reg, out_data_next;
    logic [3:0]        out_user_reg, out_user_next;

    action_t             act_reg, act_next;
    logic [NODE_W-1:0]   a_reg, a_next, b_reg, b_next;
    logic [WEIGHT_W-1:0] w_reg, w_next;
    logic [ID_W-1:0]     id_reg, id_next;
    map_ent_t            ma_reg, ma_next;

    logic [SLOT_W:0] sa_reg, sa_next, sb_reg, sb_next;
    logic [SLOT_W:0] cur_reg, cur_next, cur_par_reg, cur_par_next;
    logic [SLOT_W:0] d_reg, d_next, da_reg, da_next, db_reg, db_next;
    logic            first_reg, first_next, dep_b_reg, dep_b_next, eqb_reg, eqb_next;
    logic [SLOT_W:0] na_reg, na_next, nb_reg, nb_next, steps_reg, steps_next;
    logic [SLOT_W:0] ca_reg, ca_next, cb_reg, cb_next;
    logic [SLOT_W:0] ca_par_reg, ca_par_next, cb_par_reg, cb_par_next;
    logic [WEIGHT_W-1:0] ca_w_reg, ca_w_next, cb_w_reg, cb_w_next;
    logic [ID_W-1:0] ca_id_reg, ca_id_next, cb_id_reg, cb_id_next;
    logic [SLOT_W:0] c_reg, c_next, e_reg, e_next, other_reg, other_next;
    logic [WEIGHT_W-1:0] cur_w_reg, cur_w_next;
    logic [ID_W-1:0] cur_id_reg, cur_id_next;

    status_t             res_status_reg, res_status_next;
    logic                res_exch_reg, res_exch_next;
    logic [WEIGHT_W-1:0] res_gain_reg, res_gain_next, res_rw_reg, res_rw_next;
    logic [SLOT_W-1:0]   res_rc_reg, res_rc_next, res_rp_reg, res_rp_next;
    logic [ID_W-1:0]     res_rid_reg, res_rid_next;
    logic [SLOT_W-1:0]   res_ps_reg, res_ps_next, res_pe_reg, res_pe_next;

    logic              tree_we, map_we;
    logic [SLOT_W-1:0] tree_waddr, tree_raddr;
    logic [NODE_W-1:0] map_waddr, map_raddr;
    tree_ent_t         tree_wdata, tree_rdata;
    map_ent_t          map_wdata, map_rdata;
    logic [TREE_W-1:0] tree_rbits;
    logic [MAP_W-1:0]  map_rbits;

    assign tree_rdata = tree_rbits;
    assign map_rdata  = map_rbits;

    spte_ram #(.WIDTH(TREE_W), .DEPTH(SLOTS)) u_tree_ram (
        .clk   (clk),
        .we    (tree_we),
        .waddr (tree_waddr),
        .wdata (tree_wdata),
        .raddr (tree_raddr),
        .rdata (tree_rbits)
    );

    spte_ram #(.WIDTH(MAP_W), .DEPTH(NODES)) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rbits)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb
    begin
        logic [SLOT_W:0]   par;
        logic [SLOT_W:0]   dval;
        logic              dstop;
        logic              va, vb, pick_a;
        logic [SLOT_W:0]   n;
        logic [SLOT_W:0]   c;
        logic [WEIGHT_W-1:0] rw;

        state_next      = state_reg;
        count_next      = count_reg;
        epoch_next      = epoch_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_start_next  = clr_start_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        act_next        = act_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        w_next          = w_reg;
        id_next         = id_reg;
        ma_next         = ma_reg;
        sa_next         = sa_reg;
        sb_next         = sb_reg;
        cur_next        = cur_reg;
        cur_par_next    = cur_par_reg;
        d_next          = d_reg;
        da_next         = da_reg;
        db_next         = db_reg;
        first_next      = first_reg;
        dep_b_next      = dep_b_reg;
        eqb_next        = eqb_reg;
        na_next         = na_reg;
        nb_next         = nb_reg;
        steps_next      = steps_reg;
        ca_next         = ca_reg;
        cb_next         = cb_reg;
        ca_par_next     = ca_par_reg;
        cb_par_next     = cb_par_reg;
        ca_w_next       = ca_w_reg;
        cb_w_next       = cb_w_reg;
        ca_id_next      = ca_id_reg;
        cb_id_next      = cb_id_reg;
        c_next          = c_reg;
        e_next          = e_reg;
        other_next      = other_reg;
        cur_w_next      = cur_w_reg;
        cur_id_next     = cur_id_reg;
        res_status_next = res_status_reg;
        res_exch_next   = res_exch_reg;
        res_gain_next   = res_gain_reg;
        res_rw_next     = res_rw_reg;
        res_rc_next     = res_rc_reg;
        res_rp_next     = res_rp_reg;
        res_rid_next    = res_rid_reg;
        res_ps_next     = res_ps_reg;
        res_pe_next     = res_pe_reg;

        tree_we    = 1'b0;
        tree_waddr = cur_par_reg[SLOT_W-1:0];
        tree_wdata = '{parent: cur_reg, weight: cur_w_reg, edge_id: cur_id_reg};
        tree_raddr = cur_reg[SLOT_W-1:0];
        map_we     = 1'b0;
        map_waddr  = a_reg;
        map_wdata  = '{epoch: epoch_reg, slot: NO_SLOT};
        map_raddr  = a_reg;

        par    = up_of(cur_reg, tree_rdata.parent, count_reg);
        dval   = '0;
        dstop  = 1'b0;
        va     = (ma_reg.epoch == epoch_reg) && (ma_reg.slot < count_reg);
        vb     = (map_rdata.epoch == epoch_reg) && (map_rdata.slot < count_reg);
        pick_a = 1'b0;
        n      = NO_SLOT;
        c      = NO_SLOT;
        rw     = '0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next        = action_t'(s_tuser);
                    a_next          = s_tdata[9:0];
                    b_next          = s_tdata[19:10];
                    w_next          = s_tdata[51:20];
                    id_next         = s_tdata[67:52];
                    res_status_next = STS_OK;
                    res_exch_next   = 1'b0;
                    res_gain_next   = '0;
                    res_rw_next     = '0;
                    res_rc_next     = '0;
                    res_rp_next     = '0;
                    res_rid_next    = '0;
                    res_ps_next     = '0;
                    res_pe_next     = '0;
                    case (action_t'(s_tuser))
                        ACT_START:
                        begin
                            if (epoch_reg == '1)
                            begin
                                clr_start_next = 1'b1;
                                clr_cnt_next   = '0;
                                state_next     = S_CLR;
                            end
                            else
                            begin
                                state_next = S_ST_FIN;
                            end
                        end
                        ACT_ADD:
                        begin
                            if (s_tdata[51:20] == INF_WEIGHT)
                            begin
                                res_status_next = STS_INFINITE;
                                state_next      = S_OUT;
                            end
                            else if (count_reg == SLOT_LIMIT)
                            begin
                                res_status_next = STS_FULL;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                state_next = S_LK_B;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            state_next = S_LK_A;
                        end
                        default:
                        begin
                            if (s_tdata[51:20] == INF_WEIGHT)
                            begin
                                res_status_next = STS_INFINITE;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                state_next = S_LK_A;
                            end
                        end
                    endcase
                end
            end

            S_CLR:
            begin
                map_we       = 1'b1;
                map_waddr    = clr_cnt_reg;
                map_wdata    = '{epoch: '0, slot: NO_SLOT};
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    state_next = clr_start_reg ? S_ST_FIN : S_IDLE;
                end
            end

            S_ST_FIN:
            begin
                epoch_next = epoch_reg + 1'b1;
                map_we     = 1'b1;
                map_waddr  = a_reg;
                map_wdata  = '{epoch: epoch_reg + 1'b1, slot: '0};
                tree_we    = 1'b1;
                tree_waddr = '0;
                tree_wdata = '{parent: NO_SLOT, weight: '0, edge_id: '0};
                count_next = (SLOT_W + 1)'(1);
                state_next = S_OUT;
            end

            S_LK_A:
            begin
                map_raddr  = a_reg;
                state_next = (act_reg == ACT_REMOVE) ? S_LK_CHK : S_LK_B;
            end

            S_LK_B:
            begin
                map_raddr  = b_reg;
                ma_next    = map_rdata;
                state_next = S_LK_CHK;
            end

            S_LK_CHK:
            begin
                state_next = S_OUT;
                case (act_reg)
                    ACT_ADD:
                    begin
                        if (!vb)
                        begin
                            res_status_next = STS_NOT_IN_TREE;
                        end
                        else
                        begin
                            map_we     = 1'b1;
                            map_waddr  = a_reg;
                            map_wdata  = '{epoch: epoch_reg, slot: count_reg};
                            tree_we    = 1'b1;
                            tree_waddr = count_reg[SLOT_W-1:0];
                            tree_wdata = '{parent: map_rdata.slot, weight: w_reg,
                                           edge_id: id_reg};
                            count_next = count_reg + 1'b1;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (!vb)
                        begin
                            res_status_next = STS_NOT_IN_TREE;
                        end
                        else if (map_rdata.slot != count_reg - 1'b1)
                        begin
                            res_status_next = STS_NOT_LAST;
                        end
                        else
                        begin
                            map_we     = 1'b1;
                            map_waddr  = a_reg;
                            map_wdata  = '{epoch: epoch_reg, slot: NO_SLOT};
                            count_next = map_rdata.slot;
                        end
                    end
                    default:
                    begin
                        if (!va || !vb)
                        begin
                            res_status_next = STS_NOT_IN_TREE;
                        end
                        else if (ma_reg.slot != map_rdata.slot)
                        begin
                            sa_next    = ma_reg.slot;
                            sb_next    = map_rdata.slot;
                            cur_next   = ma_reg.slot;
                            first_next = 1'b1;
                            dep_b_next = 1'b0;
                            d_next     = '0;
                            state_next = S_DEP_RD;
                        end
                    end
                endcase
            end

            S_DEP_RD:
            begin
                tree_raddr = cur_reg[SLOT_W-1:0];
                state_next = S_DEP_EV;
            end

            S_DEP_EV:
            begin
                // The depth walk stops at a missing parent or after a full slot count.
                if (first_reg)
                begin
                    first_next = 1'b0;
                    dval       = '0;
                    dstop      = (par == NO_SLOT);
                end
                else
                begin
                    dval  = d_reg + 1'b1;
                    dstop = (par == NO_SLOT) || (dval == SLOT_LIMIT);
                end
                d_next   = dval;
                cur_next = par;
                state_next = S_DEP_RD;
                if (dstop)
                begin
                    if (!dep_b_reg)
                    begin
                        da_next    = dval;
                        dep_b_next = 1'b1;
                        cur_next   = sb_reg;
                        first_next = 1'b1;
                        d_next     = '0;
                    end
                    else
                    begin
                        db_next    = dval;
                        na_next    = sa_reg;
                        nb_next    = sb_reg;
                        ca_next    = NO_SLOT;
                        cb_next    = NO_SLOT;
                        state_next = S_EQ_RD;
                    end
                end
            end

            S_EQ_RD:
            begin
                if (db_reg < da_reg)
                begin
                    tree_raddr = na_reg[SLOT_W-1:0];
                    eqb_next   = 1'b0;
                    state_next = S_EQ_EV;
                end
                else if (da_reg < db_reg)
                begin
                    tree_raddr = nb_reg[SLOT_W-1:0];
                    eqb_next   = 1'b1;
                    state_next = S_EQ_EV;
                end
                else
                begin
                    steps_next = '0;
                    state_next = S_CL_CHK;
                end
            end

            S_EQ_EV:
            begin
                state_next = S_EQ_RD;
                if (!eqb_reg)
                begin
                    n = na_reg;
                    if (n < count_reg && (ca_reg == NO_SLOT || ca_w_reg < tree_rdata.weight))
                    begin
                        ca_next     = n;
                        ca_w_next   = tree_rdata.weight;
                        ca_id_next  = tree_rdata.edge_id;
                        ca_par_next = up_of(n, tree_rdata.parent, count_reg);
                    end
                    na_next = up_of(n, tree_rdata.parent, count_reg);
                    da_next = da_reg - 1'b1;
                end
                else
                begin
                    n = nb_reg;
                    if (n < count_reg && (cb_reg == NO_SLOT || cb_w_reg < tree_rdata.weight))
                    begin
                        cb_next     = n;
                        cb_w_next   = tree_rdata.weight;
                        cb_id_next  = tree_rdata.edge_id;
                        cb_par_next = up_of(n, tree_rdata.parent, count_reg);
                    end
                    nb_next = up_of(n, tree_rdata.parent, count_reg);
                    db_next = db_reg - 1'b1;
                end
            end

            S_CL_CHK:
            begin
                if (na_reg != nb_reg && !steps_reg[SLOT_W])
                begin
                    state_next = S_CL_RA;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end

            S_CL_RA:
            begin
                tree_raddr = na_reg[SLOT_W-1:0];
                state_next = S_CL_RB;
            end

            S_CL_RB:
            begin
                tree_raddr = nb_reg[SLOT_W-1:0];
                n = na_reg;
                if (n < count_reg && (ca_reg == NO_SLOT || ca_w_reg < tree_rdata.weight))
                begin
                    ca_next     = n;
                    ca_w_next   = tree_rdata.weight;
                    ca_id_next  = tree_rdata.edge_id;
                    ca_par_next = up_of(n, tree_rdata.parent, count_reg);
                end
                na_next    = up_of(n, tree_rdata.parent, count_reg);
                state_next = S_CL_EB;
            end

            S_CL_EB:
            begin
                n = nb_reg;
                if (n < count_reg && (cb_reg == NO_SLOT || cb_w_reg < tree_rdata.weight))
                begin
                    cb_next     = n;
                    cb_w_next   = tree_rdata.weight;
                    cb_id_next  = tree_rdata.edge_id;
                    cb_par_next = up_of(n, tree_rdata.parent, count_reg);
                end
                nb_next    = up_of(n, tree_rdata.parent, count_reg);
                steps_next = steps_reg + 1'b1;
                state_next = S_CL_CHK;
            end

            S_DECIDE:
            begin
                state_next = S_OUT;
                pick_a = (ca_reg != NO_SLOT) && (cb_reg == NO_SLOT || cb_w_reg < ca_w_reg);
                c      = pick_a ? ca_reg : cb_reg;
                rw     = pick_a ? ca_w_reg : cb_w_reg;
                // A broken tree, a cycle with no tree edge or a max below the new weight changes nothing.
                if (na_reg == nb_reg && na_reg != NO_SLOT &&
                    (ca_reg != NO_SLOT || cb_reg != NO_SLOT) && !(rw < w_reg))
                begin
                    c_next        = c;
                    e_next        = pick_a ? sa_reg : sb_reg;
                    other_next    = pick_a ? sb_reg : sa_reg;
                    res_exch_next = 1'b1;
                    res_gain_next = rw - w_reg;
                    res_rc_next   = c[SLOT_W-1:0];
                    res_rp_next   = pick_a ? ca_par_reg[SLOT_W-1:0] : cb_par_reg[SLOT_W-1:0];
                    if ((pick_a ? ca_par_reg : cb_par_reg) == NO_SLOT)
                    begin
                        res_rp_next = '0;
                    end
                    res_rw_next   = rw;
                    res_rid_next  = pick_a ? ca_id_reg : cb_id_reg;
                    res_ps_next   = pick_a ? sa_reg[SLOT_W-1:0] : sb_reg[SLOT_W-1:0];
                    res_pe_next   = c[SLOT_W-1:0];
                    state_next    = S_RV_RE;
                end
            end

            S_RV_RE:
            begin
                tree_raddr = e_reg[SLOT_W-1:0];
                state_next = S_RV_EE;
            end

            S_RV_EE:
            begin
                cur_next     = e_reg;
                cur_par_next = up_of(e_reg, tree_rdata.parent, count_reg);
                cur_w_next   = tree_rdata.weight;
                cur_id_next  = tree_rdata.edge_id;
                steps_next   = '0;
                state_next   = S_RV_CHK;
            end

            S_RV_CHK:
            begin
                if (cur_reg != c_reg && cur_par_reg != NO_SLOT && !steps_reg[SLOT_W])
                begin
                    state_next = S_RV_RD;
                end
                else
                begin
                    state_next = S_RV_FIN;
                end
            end

            S_RV_RD:
            begin
                tree_raddr = cur_par_reg[SLOT_W-1:0];
                state_next = S_RV_EV;
            end

            S_RV_EV:
            begin
                // The slot's edge moves one step up into its parent, which now points back to the slot.
                tree_we      = 1'b1;
                tree_waddr   = cur_par_reg[SLOT_W-1:0];
                tree_wdata   = '{parent: cur_reg, weight: cur_w_reg, edge_id: cur_id_reg};
                cur_next     = cur_par_reg;
                cur_par_next = up_of(cur_par_reg, tree_rdata.parent, count_reg);
                cur_w_next   = tree_rdata.weight;
                cur_id_next  = tree_rdata.edge_id;
                steps_next   = steps_reg + 1'b1;
                state_next   = S_RV_CHK;
            end

            S_RV_FIN:
            begin
                tree_we    = 1'b1;
                tree_waddr = e_reg[SLOT_W-1:0];
                tree_wdata = '{parent: other_reg, weight: w_reg, edge_id: id_reg};
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {res_pe_reg, res_ps_reg, res_rid_reg, res_rw_reg,
                                      res_rp_reg, res_rc_reg, res_gain_reg};
                    out_user_next  = {res_exch_reg, res_status_reg};
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            count_reg     <= '0;
            epoch_reg     <= '0;
            clr_cnt_reg   <= '0;
            clr_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            epoch_reg     <= epoch_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_start_reg <= clr_start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg    <= out_data_next;
        out_user_reg    <= out_user_next;
        act_reg         <= act_next;
        a_reg           <= a_next;
        b_reg           <= b_next;
        w_reg           <= w_next;
        id_reg          <= id_next;
        ma_reg          <= ma_next;
        sa_reg          <= sa_next;
        sb_reg          <= sb_next;
        cur_reg         <= cur_next;
        cur_par_reg     <= cur_par_next;
        d_reg           <= d_next;
        da_reg          <= da_next;
        db_reg          <= db_next;
        first_reg       <= first_next;
        dep_b_reg       <= dep_b_next;
        eqb_reg         <= eqb_next;
        na_reg          <= na_next;
        nb_reg          <= nb_next;
        steps_reg       <= steps_next;
        ca_reg          <= ca_next;
        cb_reg          <= cb_next;
        ca_par_reg      <= ca_par_next;
        cb_par_reg      <= cb_par_next;
        ca_w_reg        <= ca_w_next;
        cb_w_reg        <= cb_w_next;
        ca_id_reg       <= ca_id_next;
        cb_id_reg       <= cb_id_next;
        c_reg           <= c_next;
        e_reg           <= e_next;
        other_reg       <= other_next;
        cur_w_reg       <= cur_w_next;
        cur_id_reg      <= cur_id_next;
        res_status_reg  <= res_status_next;
        res_exch_reg    <= res_exch_next;
        res_gain_reg    <= res_gain_next;
        res_rw_reg      <= res_rw_next;
        res_rc_reg      <= res_rc_next;
        res_rp_reg      <= res_rp_next;
        res_rid_reg     <= res_rid_next;
        res_ps_reg      <= res_ps_next;
        res_pe_reg      <= res_pe_next;
    end

endmodule
